### hw/rtl/sabs_pkg.sv
// Shared types and constants for the servo auto-balance search block.
package sabs_pkg;

   localparam int ERR_W    = 32;
   localparam int GAIN_W   = 18;
   localparam int SAFE_W   = 31;
   localparam int CH_W     = 3;
   localparam int CD_W     = 7;

   localparam logic [CD_W-1:0] SEARCH_START = 7'd10;
   localparam logic [CD_W-1:0] HOLD_VALUE   = 7'd100;
   localparam logic [CD_W-1:0] CD_ZERO      = 7'd0;
   localparam logic signed [ERR_W-1:0] MIN_ERR_CLEAR = 32'sd6553600;

   typedef enum logic {
      CMD_BALANCE = 1'b0,
      CMD_PRESET  = 1'b1
   } command_type;

   // Write controls for the per-channel stores.
   typedef struct packed {
      logic                    drive_we;
      logic                    best_we;
      logic                    min_we;
      logic signed [ERR_W-1:0] drive_data;
      logic signed [ERR_W-1:0] best_data;
      logic signed [ERR_W-1:0] min_data;
   } store_wr_type;

endpackage

### hw/rtl/sabs_step.sv
// Command step: command minus gain times error over 65536, rounded, saturated to 32 bits.
module sabs_step (
   input  logic signed [31:0] cmd,
   input  logic        [17:0] gain,
   input  logic signed [31:0] err,
   output logic signed [31:0] result
);

   logic signed [50:0] product;
   logic signed [50:0] biased;
   logic signed [34:0] delta;
   logic signed [35:0] diff;

   always_comb begin
      product = $signed({1'b0, gain}) * err;
      biased  = product + 51'sd32768;
      // Arithmetic shift floors, so the add above rounds half upward.
      delta   = 35'(biased >>> 16);
      diff    = 36'(cmd) - 36'(delta);
      if (diff > 36'sd2147483647) begin
         result = 32'sh7FFFFFFF;
      end else if (diff < -36'sd2147483648) begin
         result = 32'sh80000000;
      end else begin
         result = diff[31:0];
      end
   end

endmodule

### hw/rtl/sabs_store.sv
// Per-channel drive, best and minimum-error registers with one read/write index.
module sabs_store #(
   parameter int CHANNELS = 6,
   parameter int IDX_W    = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [IDX_W-1:0]         idx,
   input  sabs_pkg::store_wr_type   wr,
   output logic signed [31:0]       drive_rd,
   output logic signed [31:0]       best_rd,
   output logic signed [31:0]       min_rd
);

   import sabs_pkg::*;

   logic signed [ERR_W-1:0] drive_ff [CHANNELS];
   logic signed [ERR_W-1:0] best_ff  [CHANNELS];
   logic signed [ERR_W-1:0] min_ff   [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            drive_ff[i] <= '0;
            best_ff[i]  <= '0;
            min_ff[i]   <= MIN_ERR_CLEAR;
         end
      end else begin
         if (wr.drive_we) begin
            drive_ff[idx] <= wr.drive_data;
         end
         if (wr.best_we) begin
            best_ff[idx] <= wr.best_data;
         end
         if (wr.min_we) begin
            min_ff[idx] <= wr.min_data;
         end
      end
   end

   assign drive_rd = drive_ff[idx];
   assign best_rd  = best_ff[idx];
   assign min_rd   = min_ff[idx];

endmodule

### hw/rtl/servo_auto_balance_search_core.sv
// Servo auto-balance search core: input register, per-channel update, result register.
// A beat accepted on the request side passes through the input register and then the result
// register before it leaves on the response side.
// Throughput: one beat per cycle while the response side does not stall; the update between
// the input register and the result register is one 19x32 multiply plus saturating subtract.
// Reset (synchronous, active high) clears the drive and best commands, sets every minimum
// error to 100.0, the countdown to 100, and empties both pipeline registers.
module servo_auto_balance_search_core #(
   parameter int CHANNELS = 6
) (
   input  logic          clock,
   input  logic          reset,
   // Request channel.
   input  logic          req_tvalid,
   output logic          req_tready,
   // tdata fields from bit 0: channel(3), servo_error(32), gain(18), safe_range(31),
   // preset_value(32), zero fill(4).
   input  logic [119:0]  req_tdata,
   // tuser fields from bit 0: command(1).
   input  logic [0:0]    req_tuser,
   input  logic          req_tlast,
   // Response channel.
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tdata fields from bit 0: channel_out(3), drive_command(32), best_command_out(32),
   // balancing(1), countdown_out(7), zero fill(5).
   output logic [79:0]   rsp_tdata,
   output logic          rsp_tlast
);

   import sabs_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

   // Input register. It loads whenever it is empty or its beat moves on.
   logic                     in_valid_ff;
   command_type              in_cmd_ff;
   logic [CH_W-1:0]          in_ch_ff;
   logic signed [ERR_W-1:0]  in_err_ff;
   logic [GAIN_W-1:0]        in_gain_ff;
   logic [SAFE_W-1:0]        in_safe_ff;
   logic signed [ERR_W-1:0]  in_preset_ff;
   logic                     in_last_ff;

   // Result register.
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [79:0]              rsp_data_ff;
   logic [79:0]              rsp_data_in;
   logic                     rsp_last_ff;
   logic                     rsp_last_in;

   // Call state shared by all channels.
   logic [CD_W-1:0]          countdown_ff;
   logic [CD_W-1:0]          countdown_in;
   logic                     unsafe_ff;
   logic                     unsafe_in;

   logic                     advance;
   logic [IDX_W-1:0]         idx;
   store_wr_type             wr;
   logic signed [ERR_W-1:0]  drive_rd;
   logic signed [ERR_W-1:0]  best_rd;
   logic signed [ERR_W-1:0]  min_rd;
   logic signed [ERR_W-1:0]  stepped;

   // The input beat moves into the result register when that register is free or drains.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign idx        = IDX_W'(in_ch_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff    <= command_type'(req_tuser[0]);
         in_ch_ff     <= req_tdata[2:0];
         in_err_ff    <= req_tdata[34:3];
         in_gain_ff   <= req_tdata[52:35];
         in_safe_ff   <= req_tdata[83:53];
         in_preset_ff <= req_tdata[115:84];
         in_last_ff   <= req_tlast;
      end
   end

   sabs_store #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .idx      (idx),
      .wr       (wr),
      .drive_rd (drive_rd),
      .best_rd  (best_rd),
      .min_rd   (min_rd)
   );

   sabs_step u_step (
      .cmd    (drive_rd),
      .gain   (in_gain_ff),
      .err    (in_err_ff),
      .result (stepped)
   );

   // Magnitude of a signed 32-bit value, exact for the most negative code.
   function automatic logic [32:0] mag33(input logic signed [31:0] v);
      logic [32:0] ext;
      ext = {v[31], v};
      return v[31] ? (33'd0 - ext) : ext;
   endfunction

   // Per-beat update. The countdown as it stands at the start of a call picks the mode
   // for every balance beat of that call; it only moves on the call's last beat.
   always_comb begin
      logic              ch_ok;
      logic              mode_search;
      logic              mode_apply;
      logic              unsafe_now;
      logic              improved;
      logic              seen;
      logic              balancing;
      logic [CD_W-1:0]   cd_out;
      logic              last_out;
      logic signed [31:0] drive_out;
      logic signed [31:0] best_out;

      ch_ok       = {2'b00, in_ch_ff} < CH_LIMIT;
      mode_search = (countdown_ff >= 7'd1) && (countdown_ff <= SEARCH_START);
      mode_apply  = (countdown_ff == CD_ZERO);
      unsafe_now  = mag33(in_err_ff) > {2'b00, in_safe_ff};
      improved    = mag33(in_err_ff) < mag33(min_rd);

      wr            = '0;
      wr.drive_data = stepped;
      wr.best_data  = drive_rd;
      wr.min_data   = in_err_ff;

      seen         = unsafe_ff;
      countdown_in = countdown_ff;
      unsafe_in    = unsafe_ff;
      balancing    = 1'b0;
      cd_out       = CD_ZERO;
      last_out     = 1'b0;
      drive_out    = '0;
      best_out     = '0;

      if (in_cmd_ff == CMD_PRESET) begin
         if (ch_ok) begin
            wr.drive_we   = advance;
            wr.drive_data = in_preset_ff;
            drive_out     = in_preset_ff;
            best_out      = best_rd;
         end
      end else begin
         if (ch_ok) begin
            if (mode_search) begin
               // A new smallest error records the command that produced it; only a
               // beat that is not an improvement counts toward the unsafe flag.
               wr.drive_we = advance;
               wr.best_we  = advance && improved;
               wr.min_we   = advance && improved;
               seen        = unsafe_ff || (!improved && unsafe_now);
               drive_out   = stepped;
               best_out    = improved ? drive_rd : best_rd;
            end else if (mode_apply) begin
               wr.drive_we   = advance;
               wr.drive_data = best_rd;
               wr.min_we     = advance;
               wr.min_data   = MIN_ERR_CLEAR;
               seen          = unsafe_ff || unsafe_now;
               drive_out     = best_rd;
               best_out      = best_rd;
            end else begin
               wr.drive_we = advance;
               seen        = unsafe_ff || unsafe_now;
               drive_out   = stepped;
               best_out    = best_rd;
            end
         end
         unsafe_in = seen;
         if (in_last_ff) begin
            // End of the call: settle the countdown and start the next call clean.
            if (mode_search) begin
               countdown_in = seen ? HOLD_VALUE : (countdown_ff - 7'd1);
            end else if (mode_apply) begin
               countdown_in = seen ? HOLD_VALUE : CD_ZERO;
               balancing    = !seen;
            end else if (!seen) begin
               countdown_in = SEARCH_START;
            end
            unsafe_in = 1'b0;
            last_out  = 1'b1;
            cd_out    = countdown_in;
         end
      end

      rsp_data_in = {5'd0, cd_out, balancing, best_out, drive_out, in_ch_ff};
      rsp_last_in = last_out;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= HOLD_VALUE;
         unsafe_ff    <= 1'b0;
      end else if (advance) begin
         countdown_ff <= countdown_in;
         unsafe_ff    <= unsafe_in;
      end
   end

   // The result register holds its beat until the consumer takes it.
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
